[src/assert_macros.svh]
// Assertion macros shared by the min coin change RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define MCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MCC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[src/mcc_pkg.sv]
// Shared types and constants for the min coin change block.
// No dependencies.
package mcc_pkg;

  localparam int DEF_MAX_COINS = 16;
  localparam int DEF_MAX_SUM   = 1023;

  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 10;
  localparam int STATUS_W = 2;
  localparam int CELL_W   = 11;

  // table codes
  localparam logic [CELL_W-1:0] NO_WAY    = 11'h7FF;
  localparam logic [CELL_W-1:0] COUNT_CAP = 11'h7FE;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_FOUND      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IMPOSSIBLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG    = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] value;
  } mcc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  min_count;
    logic [STATUS_W-1:0] status;
    logic                coins_dropped;
  } mcc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_COIN_RD,
    S_COIN_CHK,
    S_SWEEP,
    S_FINAL,
    S_DONE
  } mcc_state_t;

endpackage

[src/mcc_table.sv]
// Best-count table: one write port, two registered read ports.
// Same-cycle write/read of one entry is forwarded. Uses mcc_pkg.
module mcc_table import mcc_pkg::*; #(
  parameter int MAX_SUM = DEF_MAX_SUM,
  localparam int AW = $clog2(MAX_SUM + 1)
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_a_addr,
  input  logic [AW-1:0]     rd_b_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  output logic [CELL_W-1:0] rd_a_data,
  output logic [CELL_W-1:0] rd_b_data
);

  logic [CELL_W-1:0] mem_r [MAX_SUM+1];
  logic [CELL_W-1:0] rd_a_r, rd_b_r, fwd_data_r;
  logic              fwd_a_r, fwd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r     <= mem_r[rd_a_addr];
    rd_b_r     <= mem_r[rd_b_addr];
    fwd_a_r    <= wr_en && (wr_addr == rd_a_addr);
    fwd_b_r    <= wr_en && (wr_addr == rd_b_addr);
    fwd_data_r <= wr_data;
  end

  assign rd_a_data = fwd_a_r ? fwd_data_r : rd_a_r;
  assign rd_b_data = fwd_b_r ? fwd_data_r : rd_b_r;

endmodule

[src/min_coin_change_core.sv]
// Top level of the min coin change block: input/result channels, coin list,
// query sequencer. Uses mcc_pkg, mcc_table and assert_macros.svh.
//
// Load items (kind 0) append a nonzero denomination to a list of MAX_COINS
// entries; a load into a full list is dropped and sets a sticky flag that
// every later result reports until a clear item (kind 2) empties the list.
// Loads, clears and unused kinds give no result. A query item (kind 1) with
// target T fills the best-count table by dynamic programming and gives one
// result: it initializes entries 0..T, reads and checks each stored coin,
// sweeps entries d..T for each coin whose value d lies in 1..T, then reads
// best[T] and loads the result. The table memory does one read-modify-write
// per cycle, and that port sets the query time. A target above MAX_SUM skips
// the table and returns status 2. Either result may wait in S_DONE while an
// earlier result still waits in the output register. A new item is taken
// only when the sequencer is idle; a finished result may wait in the output
// register while loads and clears go on. No clearing pass after reset: the
// table is rewritten by every query.
`include "assert_macros.svh"

module min_coin_change_core import mcc_pkg::*; #(
  parameter int MAX_COINS = DEF_MAX_COINS,
  parameter int MAX_SUM   = DEF_MAX_SUM
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mcc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output mcc_out_t out_data
);

  localparam int AW     = $clog2(MAX_SUM + 1);
  localparam int CNT_W  = $clog2(MAX_COINS + 1);
  localparam int CIDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam logic [CNT_W-1:0]   CNT_FULL  = CNT_W'(MAX_COINS);
  localparam logic [VALUE_W-1:0] SUM_LIMIT = VALUE_W'(MAX_SUM);

  mcc_state_t state_r, state_nxt;

  // coin list
  logic [VALUE_W-1:0] coin_mem [MAX_COINS];
  logic [CNT_W-1:0]   coin_cnt_r;
  logic               ovf_r;
  logic [VALUE_W-1:0] coin_d_r;

  // query sequencing
  logic [CNT_W-1:0]    coin_idx_r, coin_idx_nxt;
  logic [AW-1:0]       tgt_r;
  logic [AW-1:0]       sum_r, sum_nxt;
  logic [AW-1:0]       dcur_r, dcur_nxt;
  logic                pipe_vld_r, pipe_vld_nxt;
  logic [AW-1:0]       pipe_addr_r;
  logic [COUNT_W-1:0]  res_count_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                res_load, out_load;

  // output register
  logic     out_valid_r;
  mcc_out_t out_r;

  // table port
  logic [AW-1:0]     rd_a_addr, rd_b_addr, wr_addr;
  logic              wr_en, init_we;
  logic [CELL_W-1:0] wr_data, rd_a_data, rd_b_data;
  logic [CELL_W-1:0] cand, relaxed;

  logic in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mcc_table #(.MAX_SUM(MAX_SUM)) u_table (
    .clk       (clk),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Relax step: best[s] = min(best[s], best[s-d] + 1), capped below NO_WAY.
  assign cand    = (rd_b_data == COUNT_CAP) ? COUNT_CAP : rd_b_data + CELL_W'(1);
  assign relaxed = ((rd_b_data != NO_WAY) && (cand < rd_a_data)) ? cand : rd_a_data;

  // The relax write lands in the cycle after its reads; init writes never overlap it.
  assign wr_en   = init_we || pipe_vld_r;
  assign wr_addr = pipe_vld_r ? pipe_addr_r : sum_r;
  assign wr_data = pipe_vld_r ? relaxed
                 : ((sum_r == '0) ? CELL_W'(0) : NO_WAY);

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    dcur_nxt     = dcur_r;
    coin_idx_nxt = coin_idx_r;
    pipe_vld_nxt = 1'b0;
    init_we      = 1'b0;
    res_load     = 1'b0;
    out_load     = 1'b0;
    rd_a_addr    = tgt_r;
    rd_b_addr    = tgt_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.kind == KIND_QUERY)) begin
          state_nxt = (in_data.value > SUM_LIMIT) ? S_DONE : S_INIT;
          sum_nxt   = '0;
        end
      end
      S_INIT: begin
        init_we = 1'b1;
        if (sum_r == tgt_r) begin
          coin_idx_nxt = '0;
          state_nxt    = S_COIN_RD;
        end else begin
          sum_nxt = sum_r + AW'(1);
        end
      end
      S_COIN_RD: begin
        // coin_d_r picks up coin_mem[coin_idx_r] at this edge
        state_nxt = (coin_idx_r == coin_cnt_r) ? S_FINAL : S_COIN_CHK;
      end
      S_COIN_CHK: begin
        if ((coin_d_r == '0) || (coin_d_r > VALUE_W'(tgt_r))) begin
          coin_idx_nxt = coin_idx_r + CNT_W'(1);
          state_nxt    = S_COIN_RD;
        end else begin
          sum_nxt   = coin_d_r[AW-1:0];
          dcur_nxt  = coin_d_r[AW-1:0];
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        rd_a_addr    = sum_r;
        rd_b_addr    = sum_r - dcur_r;
        pipe_vld_nxt = 1'b1;
        if (sum_r == tgt_r) begin
          coin_idx_nxt = coin_idx_r + CNT_W'(1);
          state_nxt    = S_COIN_RD;
        end else begin
          sum_nxt = sum_r + AW'(1);
        end
      end
      S_FINAL: begin
        // best[target] read was issued in S_COIN_RD
        res_load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coin_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      if (in_fire) begin
        case (in_data.kind)
          KIND_LOAD: begin
            if (in_data.value != '0) begin
              if (coin_cnt_r == CNT_FULL) begin
                ovf_r <= 1'b1;
              end else begin
                coin_cnt_r <= coin_cnt_r + CNT_W'(1);
              end
            end
          end
          KIND_CLEAR: begin
            coin_cnt_r <= '0;
            ovf_r      <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // coin memory: one write on load, one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.kind == KIND_LOAD) && (in_data.value != '0)
        && (coin_cnt_r != CNT_FULL)) begin
      coin_mem[coin_cnt_r[CIDX_W-1:0]] <= in_data.value;
    end
    coin_d_r <= coin_mem[coin_idx_r[CIDX_W-1:0]];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    dcur_r      <= dcur_nxt;
    coin_idx_r  <= coin_idx_nxt;
    pipe_addr_r <= sum_r;
    if (in_fire && (in_data.kind == KIND_QUERY)) begin
      tgt_r        <= in_data.value[AW-1:0];
      res_count_r  <= '0;
      res_status_r <= ST_TOO_BIG;
    end
    if (res_load) begin
      if (rd_a_data == NO_WAY) begin
        res_count_r  <= '0;
        res_status_r <= ST_IMPOSSIBLE;
      end else begin
        res_count_r  <= rd_a_data[CELL_W-1] ? {COUNT_W{1'b1}} : rd_a_data[COUNT_W-1:0];
        res_status_r <= ST_FOUND;
      end
    end
    if (out_load) begin
      out_r.min_count     <= res_count_r;
      out_r.status        <= res_status_r;
      out_r.coins_dropped <= ovf_r;
    end
  end

  `MCC_ASSERT_IMPL(a_out_from_done, $rose(out_valid_r), $past(state_r) == S_DONE,
                   "result raised outside S_DONE")
  `MCC_ASSERT(a_cnt_bound, coin_cnt_r <= CNT_FULL, "coin count above capacity")
  `MCC_ASSERT_IMPL(a_sweep_range, state_r == S_SWEEP,
                   (sum_r <= tgt_r) && (sum_r >= dcur_r), "sweep index out of range")
  `MCC_ASSERT(a_cnt_hold, !in_fire |=> $stable(coin_cnt_r), "coin count moved without an item")
  `MCC_ASSERT_IMPL(a_no_write_idle, state_r == S_IDLE, !wr_en, "table written while idle")

endmodule
